### sv/rbc_pkg.sv
// shared types and constants for the rc4 base-85 cipher
// used by rbc_ctrl, rbc_dp and the top level; no dependencies
package rbc_pkg;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DIR = 1'b1;

  // direction codes
  localparam logic DIR_ENC = 1'b0;
  localparam logic DIR_DEC = 1'b1;

  // base-85 armor
  localparam logic [7:0]  ARMOR_OFFSET = 8'd33;
  localparam logic [31:0] RADIX        = 32'd85;
  // floor(n / 85) == (n * DIV85_RECIP) >> DIV85_SHIFT for any 32-bit n
  localparam logic [31:0] DIV85_RECIP  = 32'd3233857729;
  localparam int unsigned DIV85_SHIFT  = 38;
  localparam logic [2:0]  GROUP_BYTES  = 3'd4;
  localparam logic [2:0]  GROUP_CHARS  = 3'd5;
  localparam logic [2:0]  LAST_DIGIT   = 3'd4;
  localparam logic [2:0]  LAST_BYTE    = 3'd3;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_START,
    OP_FILL,
    OP_SCH_RD,
    OP_SCH_J,
    OP_SCH_WN,
    OP_SCH_WJ,
    OP_KS_RD,
    OP_KS_J,
    OP_KS_WI,
    OP_KS_WJ,
    OP_KS_DATA,
    OP_ENC_PUSH,
    OP_DEC_PUSH,
    OP_DIV_LOAD,
    OP_DIV_MUL,
    OP_DIV_SUB,
    OP_EMIT_DIG,
    OP_EMIT_BYTE,
    OP_EMIT_MARK,
    OP_GROUP_CLR,
    OP_DONE
  } rbc_op_e;

  typedef struct packed {
    rbc_op_e op;
    logic    fin;
  } rbc_cmd_t;

  typedef struct packed {
    logic       mid;
    logic       last;
    logic       dir;
    logic       n_last;
    logic [2:0] fill;
    logic [2:0] cnt;
    logic       out_free;
  } rbc_status_t;

endpackage

### sv/rbc_dp.sv
// datapath: permutation memory, indexes, group word, base-85 digit unit, output register
// depends on rbc_pkg
module rbc_dp import rbc_pkg::*; #(
  parameter int unsigned KEY_BITS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rbc_cmd_t              cmd_i,
  output rbc_status_t           status_o,
  input  logic [7:0]            in_char_i,
  input  logic                  end_of_message_i,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [7:0]            out_char_o,
  output logic                  carries_data_o,
  output logic                  final_result_o
);

  // permutation memory
  logic [7:0] mem [256];
  logic [7:0] rdata_q;
  logic [7:0] raddr;
  logic       we;
  logic [7:0] waddr;
  logic [7:0] wdata;

  // configuration
  logic [KEY_BITS-1:0] key_q;
  logic                dir_q;
  logic [63:0]         key_ext;
  logic                kb;

  // cipher state
  logic [7:0]  n_q, i_q, j_q, si_q, sj_q, ks_q, ch_q;
  logic        byp_q, last_q, pad_q, mid_q;
  logic [31:0] gw_q, div_n_q;
  logic [63:0] prod_q;
  logic [2:0]  fill_q, cnt_q;
  logic [6:0]  dig_q [5];

  // output register
  logic       out_valid_q, carries_q, final_q;
  logic [7:0] out_char_q;

  // combinational helpers
  logic [7:0]  i_inc, j_sch, j_ks, t_idx, ks_new;
  logic [25:0] quot;
  logic [31:0] rem32;
  logic [7:0]  gw_byte;

  assign key_ext = 64'(key_q);
  assign kb      = key_ext[n_q[5:0]];
  assign i_inc   = i_q + 8'd1;
  assign j_sch   = j_q + rdata_q + {7'd0, kb};
  assign j_ks    = j_q + rdata_q;
  assign t_idx   = si_q + sj_q;
  assign ks_new  = byp_q ? si_q : rdata_q;
  assign quot    = prod_q[63:DIV85_SHIFT];
  assign rem32   = div_n_q - 32'(quot) * RADIX;
  assign gw_byte = 8'(gw_q >> {(2'd3 - cnt_q[1:0]), 3'b000});

  // memory address and write selection
  always_comb begin
    raddr = n_q;
    we    = 1'b0;
    waddr = n_q;
    wdata = n_q;
    unique case (cmd_i.op)
      OP_FILL: we = 1'b1;
      OP_SCH_RD: raddr = n_q;
      OP_SCH_J: raddr = j_sch;
      OP_SCH_WN: begin
        we    = 1'b1;
        waddr = n_q;
        wdata = rdata_q;
      end
      OP_SCH_WJ: begin
        we    = 1'b1;
        waddr = j_q;
        wdata = si_q;
      end
      OP_KS_RD: raddr = i_inc;
      OP_KS_J: raddr = j_ks;
      OP_KS_WI: begin
        we    = 1'b1;
        waddr = i_q;
        wdata = rdata_q;
      end
      OP_KS_WJ: begin
        we    = 1'b1;
        waddr = j_q;
        wdata = si_q;
        raddr = t_idx;
      end
      default: ;
    endcase
  end

  // memory port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      dir_q <= DIR_ENC;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_KEY: key_q <= cfg_data_i[KEY_BITS-1:0];
        REG_DIR: dir_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // control state of the cipher
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= '0;
      i_q    <= '0;
      j_q    <= '0;
      gw_q   <= '0;
      fill_q <= '0;
      cnt_q  <= '0;
      mid_q  <= 1'b0;
      last_q <= 1'b0;
      pad_q  <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        OP_START: begin
          last_q <= end_of_message_i;
          pad_q  <= 1'b0;
        end
        OP_FILL: begin
          n_q    <= n_q + 8'd1;
          i_q    <= '0;
          j_q    <= '0;
          gw_q   <= '0;
          fill_q <= '0;
          cnt_q  <= '0;
          mid_q  <= 1'b1;
        end
        OP_SCH_J: j_q <= j_sch;
        OP_SCH_WJ: n_q <= n_q + 8'd1;
        OP_KS_RD: i_q <= i_inc;
        OP_KS_J: j_q <= j_ks;
        OP_ENC_PUSH: begin
          gw_q   <= {gw_q[23:0], ks_q ^ (pad_q ? 8'd0 : ch_q)};
          fill_q <= fill_q + 3'd1;
          pad_q  <= 1'b1;
        end
        OP_DEC_PUSH: begin
          gw_q   <= gw_q * RADIX + {24'd0, ch_q} - {24'd0, ARMOR_OFFSET};
          fill_q <= fill_q + 3'd1;
          cnt_q  <= '0;
        end
        OP_DIV_LOAD: cnt_q <= '0;
        OP_DIV_SUB,
        OP_EMIT_DIG: cnt_q <= (cnt_q == LAST_DIGIT) ? 3'd0 : cnt_q + 3'd1;
        OP_EMIT_BYTE: cnt_q <= cnt_q + 3'd1;
        OP_GROUP_CLR: begin
          gw_q   <= '0;
          fill_q <= '0;
          cnt_q  <= '0;
        end
        OP_DONE: begin
          if (last_q) begin
            mid_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_START: ch_q <= in_char_i;
      OP_SCH_J,
      OP_KS_J: si_q <= rdata_q;
      OP_KS_WI: sj_q <= rdata_q;
      OP_KS_WJ: byp_q <= (t_idx == j_q);
      OP_KS_DATA: ks_q <= ks_new;
      OP_DIV_LOAD: div_n_q <= gw_q;
      OP_DIV_MUL: prod_q <= 64'(div_n_q) * 64'(DIV85_RECIP);
      OP_DIV_SUB: begin
        div_n_q <= 32'(quot);
        dig_q[0] <= rem32[6:0];
        for (int k = 1; k < 5; k++) begin
          dig_q[k] <= dig_q[k-1];
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      carries_q   <= 1'b0;
      final_q     <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        OP_EMIT_DIG: begin
          out_valid_q <= 1'b1;
          out_char_q  <= {1'b0, dig_q[cnt_q]} + ARMOR_OFFSET;
          carries_q   <= 1'b1;
          final_q     <= cmd_i.fin;
        end
        OP_EMIT_BYTE: begin
          out_valid_q <= 1'b1;
          out_char_q  <= gw_byte ^ ks_q;
          carries_q   <= 1'b1;
          final_q     <= cmd_i.fin;
        end
        OP_EMIT_MARK: begin
          out_valid_q <= 1'b1;
          out_char_q  <= 8'd0;
          carries_q   <= 1'b0;
          final_q     <= 1'b1;
        end
        default: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
          end
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_char_o     = out_char_q;
  assign carries_data_o = carries_q;
  assign final_result_o = final_q;

  // status back to the controller
  assign status_o.mid      = mid_q;
  assign status_o.last     = last_q;
  assign status_o.dir      = dir_q;
  assign status_o.n_last   = (n_q == 8'd255);
  assign status_o.fill     = fill_q;
  assign status_o.cnt      = cnt_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // group fill never passes one full armor group
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= GROUP_CHARS)
    else $error("group fill out of range");

endmodule

### sv/rbc_ctrl.sv
// controller state machine sequencing schedule, keystream, packing and output
// depends on rbc_pkg
module rbc_ctrl import rbc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  rbc_status_t status_i,
  output rbc_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_FILL,
    S_SCH_RD,
    S_SCH_J,
    S_SCH_WN,
    S_SCH_WJ,
    S_MODE,
    S_KS_RD,
    S_KS_J,
    S_KS_WI,
    S_KS_WJ,
    S_KS_DATA,
    S_ENC_PUSH,
    S_DIV_LOAD,
    S_DIV_MUL,
    S_DIV_SUB,
    S_DIG_EMIT,
    S_DEC_EMIT,
    S_MARK,
    S_CLR,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  // next state and command decode
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    cmd_o.fin  = 1'b0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_START;
          state_d  = status_i.mid ? S_MODE : S_FILL;
        end
      end
      S_FILL: begin
        cmd_o.op = OP_FILL;
        if (status_i.n_last) begin
          state_d = S_SCH_RD;
        end
      end
      S_SCH_RD: begin
        cmd_o.op = OP_SCH_RD;
        state_d  = S_SCH_J;
      end
      S_SCH_J: begin
        cmd_o.op = OP_SCH_J;
        state_d  = S_SCH_WN;
      end
      S_SCH_WN: begin
        cmd_o.op = OP_SCH_WN;
        state_d  = S_SCH_WJ;
      end
      S_SCH_WJ: begin
        cmd_o.op = OP_SCH_WJ;
        state_d  = status_i.n_last ? S_MODE : S_SCH_RD;
      end
      S_MODE: begin
        if (status_i.dir == DIR_ENC) begin
          state_d = S_KS_RD;
        end else begin
          cmd_o.op = OP_DEC_PUSH;
          if (status_i.fill >= GROUP_BYTES) begin
            state_d = S_KS_RD;
          end else if (status_i.last) begin
            state_d = S_MARK;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_KS_RD: begin
        cmd_o.op = OP_KS_RD;
        state_d  = S_KS_J;
      end
      S_KS_J: begin
        cmd_o.op = OP_KS_J;
        state_d  = S_KS_WI;
      end
      S_KS_WI: begin
        cmd_o.op = OP_KS_WI;
        state_d  = S_KS_WJ;
      end
      S_KS_WJ: begin
        cmd_o.op = OP_KS_WJ;
        state_d  = S_KS_DATA;
      end
      S_KS_DATA: begin
        cmd_o.op = OP_KS_DATA;
        state_d  = (status_i.dir == DIR_ENC) ? S_ENC_PUSH : S_DEC_EMIT;
      end
      S_ENC_PUSH: begin
        cmd_o.op = OP_ENC_PUSH;
        if (status_i.fill >= LAST_BYTE) begin
          state_d = S_DIV_LOAD;
        end else if (status_i.last) begin
          state_d = S_KS_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIV_LOAD: begin
        cmd_o.op = OP_DIV_LOAD;
        state_d  = S_DIV_MUL;
      end
      S_DIV_MUL: begin
        cmd_o.op = OP_DIV_MUL;
        state_d  = S_DIV_SUB;
      end
      S_DIV_SUB: begin
        cmd_o.op = OP_DIV_SUB;
        state_d  = (status_i.cnt == LAST_DIGIT) ? S_DIG_EMIT : S_DIV_MUL;
      end
      S_DIG_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.op  = OP_EMIT_DIG;
          cmd_o.fin = status_i.last && (status_i.cnt == LAST_DIGIT);
          if (status_i.cnt == LAST_DIGIT) begin
            state_d = S_CLR;
          end
        end
      end
      S_DEC_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.op  = OP_EMIT_BYTE;
          cmd_o.fin = status_i.last && (status_i.cnt == LAST_BYTE);
          state_d   = (status_i.cnt == LAST_BYTE) ? S_CLR : S_KS_RD;
        end
      end
      S_MARK: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_EMIT_MARK;
          state_d  = S_CLR;
        end
      end
      S_CLR: begin
        cmd_o.op = OP_GROUP_CLR;
        state_d  = S_DONE;
      end
      S_DONE: begin
        cmd_o.op = OP_DONE;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // a result is loaded only into a free output register
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_EMIT_DIG || cmd_o.op == OP_EMIT_BYTE || cmd_o.op == OP_EMIT_MARK)
    |-> status_i.out_free)
    else $error("result loaded over a pending transfer");

  // the schedule has run before any character is processed
  a_mode_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MODE) |-> status_i.mid)
    else $error("character processed without key schedule");

  // digit extraction starts only on a full group
  a_div_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV_LOAD) |-> (status_i.fill >= GROUP_BYTES))
    else $error("armor conversion of a partial group");

endmodule

### sv/rc4_bitkey_base85_cipher.sv
// top level of the rc4 stream cipher with base-85 armor
// depends on rbc_pkg, rbc_ctrl and rbc_dp
//
// One character is taken at a time and its results leave through a registered
// output. The first character of each message first rebuilds the 256-entry
// permutation and runs the bit-keyed schedule (read, j, write n and write j
// steps per entry). Every keystream byte takes read, j, write i, write j and
// data steps on the permutation memory. An encode character that closes a
// group adds base-85 digit extraction (one multiply and one subtract per
// digit), the output of its five digits and one group clear, plus one
// keystream byte per zero pad byte at the end of a message. A decode
// character that completes a group of five sends its four bytes; one that
// ends a message short of a group sends the closing marker. Output stalls
// hold these steps until the output register is free.
module rc4_bitkey_base85_cipher import rbc_pkg::*; #(
  parameter int unsigned KEY_BITS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            in_char_i,
  input  logic                  end_of_message_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_char_o,
  output logic                  carries_data_o,
  output logic                  final_result_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  rbc_cmd_t    cmd;
  rbc_status_t status;

  // configuration writes always complete
  assign cfg_ready_o = 1'b1;

  rbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rbc_dp #(
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .in_char_i        (in_char_i),
    .end_of_message_i (end_of_message_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .out_char_o       (out_char_o),
    .carries_data_o   (carries_data_o),
    .final_result_o   (final_result_o)
  );

endmodule
